### rtl/frame_luma_contrast_check_macros.svh
// Assertion macros for the frame luma contrast check
`ifndef FRAME_LUMA_CONTRAST_CHECK_MACROS_SVH
`define FRAME_LUMA_CONTRAST_CHECK_MACROS_SVH

`ifndef SYNTH
`define FLCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("flcc assertion failed");
`define FLCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("flcc assertion failed");
`else
`define FLCC_ASSERT(lbl, prop)
`define FLCC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/flcc_pkg.sv
`default_nettype none

package flcc_pkg;

  localparam int unsigned MAX_PIXELS = 1048576;

  localparam int unsigned LUMA_W   = 24;
  localparam int unsigned CNT_W    = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SUM_W    = LUMA_W + $clog2(MAX_PIXELS);
  localparam int unsigned PROD_W   = LUMA_W + CNT_W;
  localparam int unsigned CMP_W    = PROD_W + 1;
  localparam int unsigned DARK_W   = 7;
  localparam int unsigned MARGIN_W = 8;
  localparam int unsigned CFG_W    = MARGIN_W;
  localparam int unsigned LIM_W    = MARGIN_W + CNT_W;
  localparam int unsigned FRAC_W   = 16;

  localparam logic [LUMA_W-1:0] W_RED   = LUMA_W'(19588);
  localparam logic [LUMA_W-1:0] W_GREEN = LUMA_W'(38470);
  localparam logic [LUMA_W-1:0] W_BLUE  = LUMA_W'(7471);

  localparam logic [MARGIN_W-1:0] FULL_SCALE = MARGIN_W'(255);

  localparam logic [DARK_W-1:0]   DARK_RESET   = DARK_W'(20);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(25);

  localparam logic REG_DARK_LIMIT = 1'b0;
  localparam logic REG_MARGIN     = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [LUMA_W-1:0] lmin;
    logic [LUMA_W-1:0] lmax;
    logic [CNT_W-1:0]  cnt;
  } snap_t;

  function automatic logic [LUMA_W-1:0] luma_of(input logic [7:0] r,
                                                input logic [7:0] g,
                                                input logic [7:0] b);
    luma_of = LUMA_W'(r) * W_RED + LUMA_W'(g) * W_GREEN + LUMA_W'(b) * W_BLUE;
  endfunction

endpackage

`default_nettype wire

### rtl/flcc_verdict.sv
`default_nettype none

module flcc_verdict (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            snap_valid_i,
  input  wire flcc_pkg::snap_t                 snap_i,
  output logic                                 snap_rdy_o,
  input  wire logic [flcc_pkg::DARK_W-1:0]     dark_limit_i,
  input  wire logic [flcc_pkg::MARGIN_W-1:0]   margin_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 image_valid_o,
  output logic                                 mean_too_extreme_o
);

  logic a_v_q, b_v_q, o_v_q;
  logic a_rdy, b_rdy, o_rdy;
  flcc_pkg::snap_t a_q;

  logic [flcc_pkg::PROD_W-1:0] b_pmin_q, b_pmax_q;
  logic [flcc_pkg::LIM_W-1:0]  b_lo_q, b_hi_q, b_mg_q;
  logic [flcc_pkg::SUM_W-1:0]  b_sum_q;
  logic                        b_sat_q;

  logic [flcc_pkg::MARGIN_W-1:0] hi_lim;
  logic [flcc_pkg::CMP_W-1:0]    sum_x, lo_x, hi_x, mg_x, pmin_x, pmax_x;
  logic                          win, min_ok, max_ok;

  logic o_img_q, o_ext_q;

  assign o_rdy      = ~o_v_q | ~out_stall_i;
  assign b_rdy      = ~b_v_q | o_rdy;
  assign a_rdy      = ~a_v_q | b_rdy;
  assign snap_rdy_o = a_rdy;

  assign hi_lim = flcc_pkg::FULL_SCALE - flcc_pkg::MARGIN_W'(dark_limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= snap_valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (o_rdy) o_v_q <= b_v_q;
    end
  end

  // snapshot of the finished frame
  always_ff @(posedge clk_i) begin
    if (snap_valid_i && a_rdy) begin
      a_q <= snap_i;
    end
  end

  // products against the pixel count
  always_ff @(posedge clk_i) begin
    if (a_v_q && b_rdy) begin
      b_pmin_q <= flcc_pkg::PROD_W'(a_q.lmin) * flcc_pkg::PROD_W'(a_q.cnt);
      b_pmax_q <= flcc_pkg::PROD_W'(a_q.lmax) * flcc_pkg::PROD_W'(a_q.cnt);
      b_lo_q   <= flcc_pkg::LIM_W'(dark_limit_i) * flcc_pkg::LIM_W'(a_q.cnt);
      b_hi_q   <= flcc_pkg::LIM_W'(hi_lim) * flcc_pkg::LIM_W'(a_q.cnt);
      b_mg_q   <= flcc_pkg::LIM_W'(margin_i) * flcc_pkg::LIM_W'(a_q.cnt);
      b_sum_q  <= a_q.sum;
      b_sat_q  <= (a_q.cnt >= flcc_pkg::CNT_MAX);
    end
  end

  always_comb begin
    sum_x  = flcc_pkg::CMP_W'(b_sum_q);
    lo_x   = flcc_pkg::CMP_W'({b_lo_q, {flcc_pkg::FRAC_W{1'b0}}});
    hi_x   = flcc_pkg::CMP_W'({b_hi_q, {flcc_pkg::FRAC_W{1'b0}}});
    mg_x   = flcc_pkg::CMP_W'({b_mg_q, {flcc_pkg::FRAC_W{1'b0}}});
    pmin_x = flcc_pkg::CMP_W'(b_pmin_q);
    pmax_x = flcc_pkg::CMP_W'(b_pmax_q);
    win    = (sum_x > lo_x) && (sum_x < hi_x);
    min_ok = (pmin_x + mg_x) < sum_x;
    max_ok = pmax_x > (sum_x + mg_x);
  end

  always_ff @(posedge clk_i) begin
    if (b_v_q && o_rdy) begin
      o_img_q <= win & min_ok & max_ok & ~b_sat_q;
      o_ext_q <= ~win;
    end
  end

  assign out_valid_o        = o_v_q;
  assign image_valid_o      = o_img_q;
  assign mean_too_extreme_o = o_ext_q;

endmodule

`default_nettype wire

### rtl/frame_luma_contrast_check.sv
// Channel  | Signals                                      | Direction
// ---------+----------------------------------------------+----------
// pixel    | in_valid_i, in_stall_o, red/green/blue/last  | in
// verdict  | out_valid_o, out_stall_i, image_valid/mean.. | out
// config   | cfg_we_i, cfg_idx_i, cfg_data_i              | in
//
// One pixel word per cycle while in_stall_o is low; a verdict word passes the
// input, luma, snapshot, product and result regs after its last pixel is taken.
// Reset clears the frame statistics and loads dark_limit 20 and margin 25.
// A stalled verdict backs up only the last-pixel path; ordinary pixels keep
// flowing until a further last pixel finds the verdict stages full.

`default_nettype none

`include "frame_luma_contrast_check_macros.svh"

module frame_luma_contrast_check (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [flcc_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     red_i,
  input  wire logic [7:0]                     green_i,
  input  wire logic [7:0]                     blue_i,
  input  wire logic                           last_pixel_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                image_valid_o,
  output logic                                mean_too_extreme_o
);

  logic [flcc_pkg::DARK_W-1:0]   dark_q;
  logic [flcc_pkg::MARGIN_W-1:0] margin_q;

  logic       s1_v_q, s1_last_q;
  logic [7:0] s1_red_q, s1_green_q, s1_blue_q;
  logic                        s2_v_q, s2_last_q;
  logic [flcc_pkg::LUMA_W-1:0] s2_luma_q;

  logic                        started_q;
  logic [flcc_pkg::LUMA_W-1:0] min_q, max_q, min_d, max_d;
  logic [flcc_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [flcc_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  logic s1_rdy, s2_rdy, s2_go, snap_rdy, snap_valid;
  flcc_pkg::snap_t snap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q   <= flcc_pkg::DARK_RESET;
      margin_q <= flcc_pkg::MARGIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        flcc_pkg::REG_DARK_LIMIT: dark_q   <= cfg_data_i[flcc_pkg::DARK_W-1:0];
        flcc_pkg::REG_MARGIN:     margin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s2_go      = s2_v_q & (~s2_last_q | snap_rdy);
  assign s2_rdy     = ~s2_v_q | s2_go;
  assign s1_rdy     = ~s1_v_q | s2_rdy;
  assign in_stall_o = ~s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_rdy) begin
      s1_red_q   <= red_i;
      s1_green_q <= green_i;
      s1_blue_q  <= blue_i;
      s1_last_q  <= last_pixel_i;
    end
    if (s1_v_q && s2_rdy) begin
      s2_luma_q <= flcc_pkg::luma_of(s1_red_q, s1_green_q, s1_blue_q);
      s2_last_q <= s1_last_q;
    end
  end

  // fold the pixel into the frame statistics
  always_comb begin
    if (!started_q) begin
      min_d = s2_luma_q;
      max_d = s2_luma_q;
    end else begin
      min_d = (s2_luma_q < min_q) ? s2_luma_q : min_q;
      max_d = (s2_luma_q > max_q) ? s2_luma_q : max_q;
    end
    if (cnt_q < flcc_pkg::CNT_MAX) begin
      sum_d = sum_q + flcc_pkg::SUM_W'(s2_luma_q);
      cnt_d = cnt_q + flcc_pkg::CNT_W'(1);
    end else begin
      sum_d = sum_q;
      cnt_d = cnt_q;
    end
  end

  assign snap_valid = s2_go & s2_last_q;
  assign snap.sum   = sum_d;
  assign snap.lmin  = min_d;
  assign snap.lmax  = max_d;
  assign snap.cnt   = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      min_q     <= '0;
      max_q     <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end else if (s2_go) begin
      if (s2_last_q) begin
        started_q <= 1'b0;
        min_q     <= '0;
        max_q     <= '0;
        sum_q     <= '0;
        cnt_q     <= '0;
      end else begin
        started_q <= 1'b1;
        min_q     <= min_d;
        max_q     <= max_d;
        sum_q     <= sum_d;
        cnt_q     <= cnt_d;
      end
    end
  end

  flcc_verdict u_verdict (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .snap_valid_i       (snap_valid),
    .snap_i             (snap),
    .snap_rdy_o         (snap_rdy),
    .dark_limit_i       (dark_q),
    .margin_i           (margin_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .image_valid_o      (image_valid_o),
    .mean_too_extreme_o (mean_too_extreme_o)
  );

  `FLCC_ASSERT(a_cnt_bound, cnt_q <= flcc_pkg::CNT_MAX)
  `FLCC_ASSERT(a_started_cnt, started_q == (cnt_q != '0))
  `FLCC_ASSERT(a_stall_full, !in_stall_o || (s1_v_q && s2_v_q && s2_last_q))
  `FLCC_ASSERT_NEXT(a_clear_after_last, s2_go && s2_last_q, !started_q && cnt_q == '0)

endmodule

`default_nettype wire
